### src/sb5_pkg.sv
`default_nettype none

package sb5_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned ROW_W      = DIM_W + 1;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned OUT_CH     = 3;
  localparam int unsigned DATA_W     = OUT_CH * PIX_W;
  localparam int unsigned NROWS      = 4;
  localparam int unsigned NTAPS      = 5;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = FIFO_AW + 2;
  localparam int unsigned RECIP_W    = 13;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam int unsigned RECIP_SH   = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // 6554 / 2^16 gives exact floor(s / 10) for s up to 10 * 255
  localparam logic [RECIP_W-1:0] RECIP10 = 13'd6554;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    VM_ZERO,
    VM_PASS,
    VM_WEIGH
  } vmode_e;

  typedef struct packed {
    logic       vld;
    logic [1:0] rot;
    vmode_e     vmode;
    logic       hweigh;
    logic       has_out;
    logic       last;
  } ctl_t;

  function automatic logic [PIX_W-1:0] div10(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP10);
    return p[RECIP_SH +: PIX_W];
  endfunction

  function automatic logic [SUM_W-1:0] weigh5(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d,
                                              input logic [PIX_W-1:0] e);
    return SUM_W'(a) + (SUM_W'(b) << 1) + (SUM_W'(c) << 2) + (SUM_W'(d) << 1) + SUM_W'(e);
  endfunction

endpackage

`default_nettype wire

### src/sb5_line_buf.sv
`default_nettype none

module sb5_line_buf import sb5_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned LW        = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  input  wire logic                          we_i,
  input  wire logic [1:0]                    wsel_i,
  input  wire logic [LW-1:0]                 wdata_i,
  output logic      [NROWS-1:0][LW-1:0]      rdata_o
);

  for (genvar b = 0; b < NROWS; b++) begin : g_row
    logic [LW-1:0] mem [MAX_WIDTH];
    logic [LW-1:0] rd_q;

    // read returns the old entry when the same address is written
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q <= mem[addr_i];
      end
      if (we_i && (wsel_i == 2'(b))) begin
        mem[addr_i] <= wdata_i;
      end
    end

    assign rdata_o[b] = rd_q;
  end

endmodule

`default_nettype wire

### src/sb5_lane.sv
`default_nettype none

module sb5_lane import sb5_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ctl_t                         ctl_b_i,
  input  wire ctl_t                         ctl_c_i,
  input  wire ctl_t                         ctl_d_i,
  input  wire ctl_t                         ctl_e_i,
  input  wire logic [NROWS-1:0][PIX_W-1:0]  rows_i,
  input  wire logic [PIX_W-1:0]             pix_i,
  output logic      [PIX_W-1:0]             blur_o
);

  logic [SUM_W-1:0]             vsum_q;
  logic [PIX_W-1:0]             vmid_q;
  logic [PIX_W-1:0]             v;
  logic [NTAPS-1:0][PIX_W-1:0]  taps_q;
  logic [SUM_W-1:0]             hsum_q;
  logic [PIX_W-1:0]             hmid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_b_i.vld) begin
      vsum_q <= weigh5(rows_i[ctl_b_i.rot], rows_i[ctl_b_i.rot + 2'd1],
                       rows_i[ctl_b_i.rot + 2'd2], rows_i[ctl_b_i.rot + 2'd3], pix_i);
      vmid_q <= rows_i[ctl_b_i.rot + 2'd2];
    end
  end

  always_comb begin
    unique case (ctl_c_i.vmode)
      VM_WEIGH: v = div10(vsum_q);
      VM_PASS:  v = vmid_q;
      VM_ZERO:  v = '0;
      default:  v = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= '0;
    end else if (ctl_c_i.vld) begin
      taps_q <= {taps_q[NTAPS-2:0], v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_d_i.vld) begin
      hsum_q <= weigh5(taps_q[4], taps_q[3], taps_q[2], taps_q[1], taps_q[0]);
      hmid_q <= taps_q[2];
    end
  end

  assign blur_o = ctl_e_i.hweigh ? div10(hsum_q) : hmid_q;

endmodule

`default_nettype wire

### src/sb5_merge.sv
`default_nettype none

module sb5_merge import sb5_pkg::*; #(
  parameter int unsigned LW = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [LW-1:0]      lanes_i,
  input  wire logic               last_i,
  output logic [CNT_W-1:0]        cnt_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [DATA_W-1:0]       m_axis_tdata,   // blur_blue, blur_green, blur_red
  output logic                    m_axis_tlast    // last_of_frame
);

  logic [DATA_W:0]        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q;
  logic [FIFO_AW-1:0]     rd_ptr_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   pop;

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= {last_i, DATA_W'(lanes_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign cnt_o         = cnt_q;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = mem_q[rd_ptr_q][DATA_W-1:0];
  assign m_axis_tlast  = mem_q[rd_ptr_q][DATA_W];

endmodule

`default_nettype wire

### src/separable_blur_5x5_core.sv
// Path: a result passes stages b, c, d, e and the output queue on its way to m_axis;
//   the result for a pixel is completed by the input item 2*width+2 transfers later.
// Throughput: one input item per ready cycle, set by the single read/write port per line buffer.
// Reset: counters, window taps and pipeline valids clear at once; line buffers are
//   not cleared and need no clearing pass, so input is taken from the first cycle.
`default_nettype none

module separable_blur_5x5_core import sb5_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CHANNELS  = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [DIM_W-1:0]      cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [DATA_W-1:0]     s_axis_tdata,   // blue, green, red
  input  wire logic                  s_axis_tuser,   // command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [DATA_W-1:0]          m_axis_tdata,   // blur_blue, blur_green, blur_red
  output logic                       m_axis_tlast    // last_of_frame
);

  localparam int unsigned LANES  = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
  localparam int unsigned LW     = LANES * PIX_W;
  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
  localparam int unsigned WMAX   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int unsigned W_RST  = (640 < WMAX) ? 640 : WMAX;
  localparam logic [DIM_W-1:0] WMAX_L = DIM_W'(WMAX);

  logic [DIM_W-1:0]  width_q, height_q;
  logic [ROW_W-1:0]  in_row_q;
  logic [DIM_W-1:0]  in_col_q, out_row_q, out_col_q;

  logic [DIM_W-1:0]  col;
  logic [ROW_W-1:0]  r;
  logic              pix_phase, drop, accept, go, row_ge2, fire, r_in, r_full;
  logic [DIM_W-1:0]  cfg_width, cfg_height;
  ctl_t              ctl_b_d, ctl_b_q, ctl_c_q, ctl_d_q, ctl_e_q;
  logic [LW-1:0]     pix_b_q;
  logic [NROWS-1:0][LW-1:0] rdata;
  logic [LW-1:0]     lanes_out;
  logic [CNT_W-1:0]  fifo_cnt, occ;
  logic              push;

  always_comb begin
    col       = (in_col_q >= width_q) ? width_q - 1'b1 : in_col_q;
    pix_phase = in_row_q < ROW_W'(height_q);
    drop      = pix_phase && (s_axis_tuser == CMD_DRAIN);
    accept    = s_axis_tvalid && s_axis_tready;
    go        = accept && !drop;
    row_ge2   = in_row_q >= ROW_W'(2);
    r         = in_row_q - ROW_W'(2);
    r_in      = r < ROW_W'(height_q);
    r_full    = (r >= ROW_W'(2)) &&
                ((ROW_W+1)'(r) + (ROW_W+1)'(3) <= (ROW_W+1)'(height_q));

    ctl_b_d.vld     = go && row_ge2;
    ctl_b_d.rot     = in_row_q[1:0];
    ctl_b_d.vmode   = !r_in ? VM_ZERO : (r_full ? VM_WEIGH : VM_PASS);
    ctl_b_d.hweigh  = (out_col_q >= DIM_W'(2)) &&
                      ((DIM_W+1)'(out_col_q) + (DIM_W+1)'(3) <= (DIM_W+1)'(width_q));
    ctl_b_d.has_out = (r >= ROW_W'(2)) ||
                      ((r == ROW_W'(1)) && (width_q >= DIM_W'(2))) ||
                      ((r == ROW_W'(0)) && (col >= DIM_W'(2)));
    ctl_b_d.last    = (out_row_q == height_q - 1'b1) && (out_col_q == width_q - 1'b1);
    fire            = ctl_b_d.vld && ctl_b_d.has_out;

    cfg_width  = (cfg_data_i == '0) ? DIM_W'(1) :
                 ((cfg_data_i > WMAX_L) ? WMAX_L : cfg_data_i);
    cfg_height = (cfg_data_i == '0) ? DIM_W'(1) : cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(W_RST);
      height_q  <= DIM_W'(480);
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_width;
        REG_IMAGE_HEIGHT: height_q <= cfg_height;
        default:          width_q  <= width_q;
      endcase
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (go) begin
      if (fire && ctl_b_d.last) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else begin
        if (col == width_q - 1'b1) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
        end else begin
          in_col_q <= col + 1'b1;
        end
        if (fire) begin
          if (out_col_q == width_q - 1'b1) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 1'b1;
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      ctl_d_q <= '0;
      ctl_e_q <= '0;
    end else begin
      ctl_b_q <= ctl_b_d;
      ctl_c_q <= ctl_b_q;
      ctl_d_q <= ctl_c_q;
      ctl_e_q <= ctl_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      pix_b_q <= s_axis_tdata[LW-1:0];
    end
  end

  sb5_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .LW        (LW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rd_en_i (go),
    .addr_i  (AW'(col)),
    .we_i    (go && pix_phase),
    .wsel_i  (in_row_q[1:0]),
    .wdata_i (s_axis_tdata[LW-1:0]),
    .rdata_o (rdata)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [NROWS-1:0][PIX_W-1:0] lane_rows;

    always_comb begin
      for (int j = 0; j < NROWS; j++) begin
        lane_rows[j] = rdata[j][k*PIX_W +: PIX_W];
      end
    end

    sb5_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_b_i (ctl_b_q),
      .ctl_c_i (ctl_c_q),
      .ctl_d_i (ctl_d_q),
      .ctl_e_i (ctl_e_q),
      .rows_i  (lane_rows),
      .pix_i   (pix_b_q[k*PIX_W +: PIX_W]),
      .blur_o  (lanes_out[k*PIX_W +: PIX_W])
    );
  end

  assign push = ctl_e_q.vld && ctl_e_q.has_out;

  sb5_merge #(
    .LW (LW)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .lanes_i       (lanes_out),
    .last_i        (ctl_e_q.last),
    .cnt_o         (fifo_cnt),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign occ = fifo_cnt + CNT_W'(ctl_b_q.vld) + CNT_W'(ctl_c_q.vld) +
               CNT_W'(ctl_d_q.vld) + CNT_W'(ctl_e_q.vld);
  assign s_axis_tready = occ < CNT_W'(FIFO_DEPTH);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt < CNT_W'(FIFO_DEPTH)))
    else $error("output queue written while full");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && fire && ctl_b_d.last) |=> (in_row_q == '0 && in_col_q == '0 &&
                                      out_row_q == '0 && out_col_q == '0))
    else $error("counters not cleared after final pixel");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ROW_W+1)'(in_row_q) <= (ROW_W+1)'(height_q) + (ROW_W+1)'(3))
    else $error("input row ran past drain window");

endmodule

`default_nettype wire
